// File: src/sct_pkg.sv
`timescale 1ns / 1ps

package sct_pkg;

	localparam int KW_MAX_LEN = 11;
	localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);
	localparam int NUM_KW     = 11;
	localparam int NUM_TY     = 13;
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_WORD = 3'd1,
		MODE_NUM  = 3'd2,
		MODE_EQ   = 3'd3,
		MODE_LT   = 3'd4,
		MODE_GT   = 3'd5,
		MODE_BANG = 3'd6
	} scan_mode_t;

	typedef enum logic [4:0] {
		TK_IDENT    = 5'd0,
		TK_KEYWORD  = 5'd1,
		TK_TYPE     = 5'd2,
		TK_NUMBER   = 5'd3,
		TK_EQ_EQ    = 5'd4,
		TK_LE       = 5'd5,
		TK_GE       = 5'd6,
		TK_NE       = 5'd7,
		TK_PLUS     = 5'd8,
		TK_MINUS    = 5'd9,
		TK_LPAREN   = 5'd10,
		TK_RPAREN   = 5'd11,
		TK_LBRACE   = 5'd12,
		TK_RBRACE   = 5'd13,
		TK_LBRACKET = 5'd14,
		TK_RBRACKET = 5'd15,
		TK_COLON    = 5'd16,
		TK_COMMA    = 5'd17,
		TK_SEMI     = 5'd18,
		TK_ASSIGN   = 5'd19,
		TK_AT       = 5'd20,
		TK_STAR     = 5'd21,
		TK_NOT      = 5'd22
	} tok_kind_t;

	typedef logic [KW_MAX_LEN-1:0][7:0] word_t;
	typedef logic [8*KW_MAX_LEN-1:0]    lit_t;

	typedef struct packed {
		scan_mode_t   mode;
		logic         seen;
		logic [31:0]  start;
		logic [15:0]  len;
		logic [31:0]  pos;
		word_t        prefix;
	} scan_state_t;

	typedef struct packed {
		tok_kind_t    kind;
		logic [3:0]   sub;
		logic [31:0]  start;
		logic [15:0]  len;
		logic         last;
	} token_t;

	typedef struct packed {
		tok_kind_t    kind;
		logic [3:0]   sub;
	} word_class_t;

	// text is left-justified, first char in the top byte, padded with blanks
	localparam lit_t KW_TXT [NUM_KW] = '{
		"proc       ", "include    ", "let        ", {"debug", "_print"},
		"struct     ", "enum       ", "if         ", "else       ",
		"while      ", "for        ", "do         "
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd4, 4'd7, 4'd3, 4'd11, 4'd6, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2
	};

	localparam lit_t TY_TXT [NUM_TY] = '{
		"u8         ", "u16        ", "u32        ", "u64        ",
		"i8         ", "i16        ", "i32        ", "i64        ",
		"f32        ", "f64        ", "char8      ", "char16     ",
		"char32     "
	};
	localparam logic [3:0] TY_LEN [NUM_TY] = '{
		4'd2, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd5, 4'd6, 4'd6
	};

	function automatic word_class_t match_word(input word_t w, input logic [15:0] len);
		word_class_t r;
		logic        hit;
		logic        same;
		r.kind = TK_IDENT;
		r.sub  = '0;
		hit    = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			same = (len == 16'(KW_LEN[k]));
			for (int i = 0; i < KW_MAX_LEN; i++) begin
				if (i < int'(KW_LEN[k]) && w[i] != KW_TXT[k][8*(KW_MAX_LEN-1-i) +: 8])
					same = 1'b0;
			end
			if (!hit && same) begin
				hit    = 1'b1;
				r.kind = TK_KEYWORD;
				r.sub  = 4'(k);
			end
		end
		for (int k = 0; k < NUM_TY; k++) begin
			same = (len == 16'(TY_LEN[k]));
			for (int i = 0; i < KW_MAX_LEN; i++) begin
				if (i < int'(TY_LEN[k]) && w[i] != TY_TXT[k][8*(KW_MAX_LEN-1-i) +: 8])
					same = 1'b0;
			end
			if (!hit && same) begin
				hit    = 1'b1;
				r.kind = TK_TYPE;
				r.sub  = 4'(k);
			end
		end
		return r;
	endfunction

endpackage

// File: src/sct_step.sv
`timescale 1ns / 1ps

module sct_step (
	input  logic [7:0]           char_in,
	input  logic                 end_of_text,
	input  sct_pkg::scan_state_t cur,
	output sct_pkg::scan_state_t nxt,
	output sct_pkg::token_t      tok_a,
	output sct_pkg::token_t      tok_b,
	output logic [1:0]           tok_cnt
);

	typedef struct packed {
		logic            vld;
		sct_pkg::token_t tok;
	} emit_t;

	function automatic emit_t close_tok(input sct_pkg::scan_state_t s);
		emit_t                e;
		sct_pkg::word_class_t wc;
		wc          = sct_pkg::match_word(s.prefix, s.len);
		e.vld       = 1'b0;
		e.tok.kind  = sct_pkg::TK_IDENT;
		e.tok.sub   = '0;
		e.tok.start = s.start;
		e.tok.len   = s.len;
		e.tok.last  = 1'b0;
		unique case (s.mode)
			sct_pkg::MODE_WORD: begin
				e.vld      = 1'b1;
				e.tok.kind = wc.kind;
				e.tok.sub  = wc.sub;
			end
			sct_pkg::MODE_NUM: begin
				e.vld      = 1'b1;
				e.tok.kind = sct_pkg::TK_NUMBER;
			end
			sct_pkg::MODE_EQ: begin
				e.vld      = 1'b1;
				e.tok.kind = sct_pkg::TK_ASSIGN;
				e.tok.len  = 16'd1;
			end
			sct_pkg::MODE_BANG: begin
				e.vld      = 1'b1;
				e.tok.kind = sct_pkg::TK_NOT;
				e.tok.len  = 16'd1;
			end
			default: ;
		endcase
		return e;
	endfunction

	logic                 is_alpha;
	logic                 is_num;
	logic                 is_blank;
	logic                 is_dot;
	logic                 is_eq;
	logic                 is_op_mode;
	logic                 taken;
	sct_pkg::scan_state_t mid;
	emit_t                e1;
	emit_t                e2;
	emit_t                e3;
	emit_t                tail;

	assign is_alpha = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z")
		|| char_in == "_";
	assign is_num   = char_in >= "0" && char_in <= "9";
	assign is_blank = char_in == " " || (char_in >= 8'd9 && char_in <= 8'd13);
	assign is_dot   = char_in == ".";
	assign is_eq    = char_in == "=";
	assign is_op_mode = cur.mode == sct_pkg::MODE_EQ || cur.mode == sct_pkg::MODE_LT
		|| cur.mode == sct_pkg::MODE_GT || cur.mode == sct_pkg::MODE_BANG;

	always_comb begin
		unique case (cur.mode)
			sct_pkg::MODE_WORD: taken = is_alpha || is_num;
			sct_pkg::MODE_NUM:  taken = is_num || (is_dot && !cur.seen);
			sct_pkg::MODE_EQ,
			sct_pkg::MODE_LT,
			sct_pkg::MODE_GT,
			sct_pkg::MODE_BANG: taken = is_eq;
			default:            taken = 1'b0;
		endcase
	end

	always_comb begin
		mid        = cur;
		e1         = '0;
		e2         = '0;
		e2.tok.start = cur.pos;
		e2.tok.len   = 16'd1;
		if (taken) begin
			if (is_op_mode) begin
				e1.vld       = 1'b1;
				e1.tok.start = cur.start;
				e1.tok.len   = 16'd2;
				unique case (cur.mode)
					sct_pkg::MODE_EQ:   e1.tok.kind = sct_pkg::TK_EQ_EQ;
					sct_pkg::MODE_LT:   e1.tok.kind = sct_pkg::TK_LE;
					sct_pkg::MODE_GT:   e1.tok.kind = sct_pkg::TK_GE;
					default:            e1.tok.kind = sct_pkg::TK_NE;
				endcase
				mid.mode = sct_pkg::MODE_IDLE;
				mid.len  = '0;
			end else begin
				if (cur.mode == sct_pkg::MODE_WORD && cur.len < 16'(sct_pkg::KW_MAX_LEN))
					mid.prefix[cur.len[sct_pkg::KW_IDX_W-1:0]] = char_in;
				if (cur.mode == sct_pkg::MODE_NUM && is_dot)
					mid.seen = 1'b1;
				mid.len = (cur.len == 16'hFFFF) ? cur.len : cur.len + 16'd1;
			end
		end else begin
			e1       = close_tok(cur);
			mid.mode = sct_pkg::MODE_IDLE;
			mid.seen = 1'b0;
			mid.len  = '0;
			if (is_alpha) begin
				mid.mode      = sct_pkg::MODE_WORD;
				mid.start     = cur.pos;
				mid.len       = 16'd1;
				mid.prefix[0] = char_in;
			end else if (is_num) begin
				mid.mode  = sct_pkg::MODE_NUM;
				mid.start = cur.pos;
				mid.len   = 16'd1;
			end else if (!is_blank) begin
				case (char_in)
					"=": begin mid.mode = sct_pkg::MODE_EQ;   mid.start = cur.pos; end
					"<": begin mid.mode = sct_pkg::MODE_LT;   mid.start = cur.pos; end
					">": begin mid.mode = sct_pkg::MODE_GT;   mid.start = cur.pos; end
					"!": begin mid.mode = sct_pkg::MODE_BANG; mid.start = cur.pos; end
					"+": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_PLUS;     end
					"-": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_MINUS;    end
					"(": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_LPAREN;   end
					")": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_RPAREN;   end
					"{": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_LBRACE;   end
					"}": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_RBRACE;   end
					"[": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_LBRACKET; end
					"]": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_RBRACKET; end
					":": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_COLON;    end
					",": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_COMMA;    end
					";": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_SEMI;     end
					"@": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_AT;       end
					"*": begin e2.vld = 1'b1; e2.tok.kind = sct_pkg::TK_STAR;     end
					default: ;
				endcase
			end
		end
	end

	// flush at end of text
	always_comb begin
		nxt = mid;
		e3  = '0;
		if (end_of_text) begin
			e3       = close_tok(mid);
			nxt.mode = sct_pkg::MODE_IDLE;
			nxt.seen = 1'b0;
			nxt.len  = '0;
			nxt.pos  = '0;
		end else if (cur.pos != 32'hFFFF_FFFF) begin
			nxt.pos = cur.pos + 32'd1;
		end
	end

	// a punctuation beat leaves nothing pending, so e2 and e3 never coexist
	assign tail = e2.vld ? e2 : e3;

	always_comb begin
		tok_a      = e1.vld ? e1.tok : tail.tok;
		tok_a.last = !(e1.vld && tail.vld);
		tok_b      = tail.tok;
		tok_b.last = 1'b1;
		if (e1.vld && tail.vld)
			tok_cnt = 2'd2;
		else if (e1.vld || tail.vld)
			tok_cnt = 2'd1;
		else
			tok_cnt = 2'd0;
	end

endmodule

// File: src/sct_out_fifo.sv
`timescale 1ns / 1ps

module sct_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_cnt,
	input  sct_pkg::token_t push_a,
	input  sct_pkg::token_t push_b,
	input  logic            pop,
	output sct_pkg::token_t head,
	output logic            not_empty,
	output logic            room_two
);

	sct_pkg::token_t                   mem_q [sct_pkg::OUT_DEPTH];
	logic [sct_pkg::OUT_PTR_W-1:0]     wr_ptr_q;
	logic [sct_pkg::OUT_PTR_W-1:0]     rd_ptr_q;
	logic [sct_pkg::OUT_CNT_W-1:0]     count_q;
	logic                              do_pop;

	assign not_empty = count_q != '0;
	assign room_two  = count_q <= sct_pkg::OUT_CNT_W'(sct_pkg::OUT_DEPTH - 2);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sct_pkg::OUT_PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + sct_pkg::OUT_PTR_W'(do_pop);
			count_q  <= count_q + sct_pkg::OUT_CNT_W'(push_cnt) - sct_pkg::OUT_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push_a;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_q + sct_pkg::OUT_PTR_W'(1)] <= push_b;
	end

endmodule

// File: src/source_code_tokenizer.sv
`timescale 1ns / 1ps
// Streaming tokenizer: one source byte per input beat, tokens out.
// Input channel: char_in, end_of_text with in_valid / in_ready. Set
// end_of_text on the final byte of a text to flush the pending token and
// restart offsets at 0 for the next text.
// Output channel: lex_kind, sub_kind, start_offset, token_length and
// last_of_run with out_valid / out_ready. A byte yields zero, one or two
// tokens; last_of_run marks the final token a byte produced.
// Path: a byte accepted into the input register passes through the scan
// step into the result queue, whose head offers its tokens.
// Throughput: one byte per cycle; the result queue drains one token per
// cycle, so bytes that emit two tokens back to back slow input to the
// output rate. Keyword and type matching is a parallel compare in the step.
// Stall: the four-entry result queue absorbs output stalls; in_ready drops
// once fewer than two free entries remain and the input register is full.
// Reset: clears scan state, offset counter, input register and queue.
module source_code_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_in,
	input  logic        end_of_text,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [4:0]  lex_kind,
	output logic [3:0]  sub_kind,
	output logic [31:0] start_offset,
	output logic [15:0] token_length,
	output logic        last_of_run,
	output logic        out_valid,
	input  logic        out_ready
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 eot_s1;
	logic                 advance;
	logic                 room_two;
	logic [1:0]           tok_cnt;
	logic [1:0]           push_cnt;
	sct_pkg::scan_state_t state_q;
	sct_pkg::scan_state_t state_nxt;
	sct_pkg::token_t      tok_a;
	sct_pkg::token_t      tok_b;
	sct_pkg::token_t      head;

	assign advance  = valid_s1 && room_two;
	assign in_ready = !valid_s1 || advance;
	assign push_cnt = advance ? tok_cnt : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	sct_step u_step (
		.char_in     (char_s1),
		.end_of_text (eot_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.tok_a       (tok_a),
		.tok_b       (tok_b),
		.tok_cnt     (tok_cnt)
	);

	sct_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push_a    (tok_a),
		.push_b    (tok_b),
		.pop       (out_ready),
		.head      (head),
		.not_empty (out_valid),
		.room_two  (room_two)
	);

	assign lex_kind     = head.kind;
	assign sub_kind     = head.sub;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign last_of_run  = head.last;

endmodule
